// ===== hdl/ifrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ifrq_pkg
// Shared types and codes for the image flip, rotate and quadrant engine.
// ----------------------------------------------------------------------------
package ifrq_pkg;

  // Fixed field widths of the ports.
  localparam int PIX_W      = 32;
  localparam int MODE_W     = 2;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Transform operations.
  localparam logic [OP_W-1:0] OP_FLIP_V   = 3'd1;
  localparam logic [OP_W-1:0] OP_MIRROR   = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_CW   = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT_CCW  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUAD_CW  = 3'd5;
  localparam logic [OP_W-1:0] OP_QUAD_CCW = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

  // Orientation code of the unrotated view.
  localparam logic [1:0] DIR_NONE = 2'd1;

  // Composed view: orientation, flip bit and quadrant map.
  typedef struct packed {
    logic [1:0]      dir;
    logic            flip;
    logic [3:0][1:0] qmap;
  } xform_t;

  localparam xform_t XFORM_RESET = '{dir: DIR_NONE, flip: 1'b0,
                                     qmap: {2'd3, 2'd2, 2'd1, 2'd0}};

  // Flags that travel with a read through the pipeline.
  typedef struct packed {
    logic row_end;
    logic last_pixel;
  } rd_tag_t;

  // Position divider sequencer.
  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

endpackage

// ===== hdl/image_flip_rotate_quadrant_engine.sv =====
// ----------------------------------------------------------------------------
// image_flip_rotate_quadrant_engine
// Loads an image into a pixel store, composes flip, rotate and quadrant
// operations into one view and reads the transformed image back out.
//
//   Channel | Direction | Handshake       | Payload
//   in      | input     | in_valid/stall  | mode, pixel_in, op_code
//   out     | output    | out_valid/stall | pixel_out, row_end, last_pixel
//   cfg     | input     | cfg_valid/ready | index, data
//
// Loads and operations are taken back to back while no rotation holds the input.
// A read's result is registered in the address mapping stage, then in the
// store read and the output slot; one read is in flight at a time.
// A rotation stalls input and configuration while the position divider
// splits the read position.
// Reset clears all control state; the pixel store is undefined until loaded.
// A stalled result holds; loads and operations still pass behind it.
// ----------------------------------------------------------------------------
module image_flip_rotate_quadrant_engine
  import ifrq_pkg::*;
#(
  parameter int MAX_DIM    = 128,
  parameter int PIXEL_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic signed [PIX_W-1:0] in_pixel_in,
  input  logic [OP_W-1:0]         in_op_code,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] out_pixel_out,
  output logic                    out_row_end,
  output logic                    out_last_pixel,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int POS_W = $clog2(DEPTH);
  localparam int CW    = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int WIDE  = (PIXEL_BITS > PIX_W) ? PIXEL_BITS : PIX_W;

  // Registers.
  logic [DIM_W-1:0] n_r, n_nxt, m_r, m_nxt;
  xform_t           xf_r, xf_nxt;
  logic [POS_W-1:0] ld_pos_r, ld_pos_nxt, rd_pos_r, rd_pos_nxt;
  logic [DIM_W-1:0] ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [DIM_W-1:0] rd_row_r, rd_row_nxt, rd_col_r, rd_col_nxt;
  logic             out_valid_r, out_valid_nxt;
  rd_tag_t          out_tag_r, out_tag_nxt;

  // Handshakes and decode.
  logic             in_xfer, ld_xfer, op_xfer, rd_xfer, cfg_xfer, cfg_hit;
  logic             rd_busy, div_start, div_busy, div_done;
  logic [DIM_W-1:0] div_q, div_rem, div_d;
  logic [CW-1:0]    cfg_ext, cfg_lim;
  logic [DIM_W-1:0] cfg_eff;
  logic [DIM_W-1:0] cur_r, cur_c;
  logic             rd_row_end, rd_last, ld_row_end, ld_last;

  // Store interface.
  logic                  re;
  logic [POS_W-1:0]      raddr;
  rd_tag_t               rd_tag;
  logic [WIDE-1:0]       wide_in, rd_ext;
  logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;

  assign in_xfer  = in_valid && !in_stall;
  assign ld_xfer  = in_xfer && (in_mode == MODE_LOAD);
  assign op_xfer  = in_xfer && (in_mode == MODE_OP);
  assign rd_xfer  = in_xfer && (in_mode == MODE_READ);
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_xfer &&
                    ((cfg_index == REG_IMAGE_ROWS) || (cfg_index == REG_IMAGE_COLS));

  // A read waits while another is in flight or its result is held.
  assign rd_busy   = re || (out_valid_r && out_stall);
  assign in_stall  = div_busy || ((in_mode == MODE_READ) && rd_busy);
  assign cfg_ready = !div_busy;

  // Current output dimensions follow the orientation parity.
  assign cur_r = xf_r.dir[0] ? n_r : m_r;
  assign cur_c = xf_r.dir[0] ? m_r : n_r;
  assign rd_row_end = (rd_col_r == cur_c - DIM_W'(1));
  assign rd_last    = rd_row_end && (rd_row_r == cur_r - DIM_W'(1));
  assign ld_row_end = (ld_col_r == m_r - DIM_W'(1));
  assign ld_last    = ld_row_end && (ld_row_r == n_r - DIM_W'(1));

  // Clamp a dimension to the supported range and round it down to even.
  always_comb begin
    cfg_ext = CW'(cfg_data);
    if (cfg_ext < CW'(2)) begin
      cfg_lim = CW'(2);
    end else if (cfg_ext > CW'(MAX_DIM)) begin
      cfg_lim = CW'(MAX_DIM);
    end else begin
      cfg_lim = cfg_ext;
    end
    cfg_eff = DIM_W'(cfg_lim) & ~DIM_W'(1);
  end

  // Compose an operation into the view.
  always_comb begin
    xf_nxt    = xf_r;
    div_start = 1'b0;
    if (op_xfer) begin
      case (in_op_code)
        OP_FLIP_V: begin
          xf_nxt.qmap = {xf_r.qmap[1], xf_r.qmap[0], xf_r.qmap[3], xf_r.qmap[2]};
          xf_nxt.dir  = xf_r.dir[0] ? (xf_r.dir ^ 2'b10) : xf_r.dir;
          xf_nxt.flip = !xf_r.flip;
        end
        OP_MIRROR: begin
          xf_nxt.qmap = {xf_r.qmap[2], xf_r.qmap[3], xf_r.qmap[0], xf_r.qmap[1]};
          xf_nxt.dir  = xf_r.dir[0] ? xf_r.dir : (xf_r.dir ^ 2'b10);
          xf_nxt.flip = !xf_r.flip;
        end
        OP_ROT_CW: begin
          xf_nxt.qmap = {xf_r.qmap[1], xf_r.qmap[3], xf_r.qmap[0], xf_r.qmap[2]};
          xf_nxt.dir  = xf_r.dir + 2'd3;
          div_start   = 1'b1;
        end
        OP_QUAD_CW: begin
          xf_nxt.qmap = {xf_r.qmap[1], xf_r.qmap[3], xf_r.qmap[0], xf_r.qmap[2]};
        end
        OP_ROT_CCW: begin
          xf_nxt.qmap = {xf_r.qmap[2], xf_r.qmap[0], xf_r.qmap[3], xf_r.qmap[1]};
          xf_nxt.dir  = xf_r.dir + 2'd1;
          div_start   = 1'b1;
        end
        OP_QUAD_CCW: begin
          xf_nxt.qmap = {xf_r.qmap[2], xf_r.qmap[0], xf_r.qmap[3], xf_r.qmap[1]};
        end
        default: begin
          xf_nxt = xf_r;
        end
      endcase
    end
  end

  // The new output width after a rotation is the other dimension.
  assign div_d = xf_r.dir[0] ? n_r : m_r;

  // Dimensions and the load and read positions.
  always_comb begin
    n_nxt      = n_r;
    m_nxt      = m_r;
    ld_pos_nxt = ld_pos_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    rd_pos_nxt = rd_pos_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;
    if (cfg_hit) begin
      if (cfg_index == REG_IMAGE_ROWS) begin
        n_nxt = cfg_eff;
      end else begin
        m_nxt = cfg_eff;
      end
      ld_pos_nxt = '0;
      ld_row_nxt = '0;
      ld_col_nxt = '0;
      rd_pos_nxt = '0;
      rd_row_nxt = '0;
      rd_col_nxt = '0;
    end
    if (ld_xfer) begin
      if (ld_last) begin
        ld_pos_nxt = '0;
        ld_row_nxt = '0;
        ld_col_nxt = '0;
      end else begin
        ld_pos_nxt = ld_pos_r + POS_W'(1);
        ld_row_nxt = ld_row_end ? (ld_row_r + DIM_W'(1)) : ld_row_r;
        ld_col_nxt = ld_row_end ? '0 : (ld_col_r + DIM_W'(1));
      end
    end
    if (rd_xfer) begin
      if (rd_last) begin
        rd_pos_nxt = '0;
        rd_row_nxt = '0;
        rd_col_nxt = '0;
      end else begin
        rd_pos_nxt = rd_pos_r + POS_W'(1);
        rd_row_nxt = rd_row_end ? (rd_row_r + DIM_W'(1)) : rd_row_r;
        rd_col_nxt = rd_row_end ? '0 : (rd_col_r + DIM_W'(1));
      end
    end
    if (div_done) begin
      rd_row_nxt = div_q;
      rd_col_nxt = div_rem;
    end
  end

  // Output slot: filled when the store read issues, freed by a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tag_nxt   = out_tag_r;
    if (re) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = rd_tag;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= DIM_W'(2);
      m_r         <= DIM_W'(2);
      xf_r        <= XFORM_RESET;
      ld_pos_r    <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rd_pos_r    <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      xf_r        <= xf_nxt;
      ld_pos_r    <= ld_pos_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      rd_pos_r    <= rd_pos_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_col_r    <= rd_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_tag_r <= out_tag_nxt;
  end

  // Position divider for rotations.
  ifrq_div #(
    .MAX_DIM (MAX_DIM)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd_pos_r),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Inverse address mapping.
  ifrq_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (rd_xfer),
    .rd_row (rd_row_r),
    .rd_col (rd_col_r),
    .rows   (n_r),
    .cols   (m_r),
    .xform  (xf_r),
    .re     (re),
    .raddr  (raddr),
    .tag    (rd_tag)
  );

  // Pixel store: keeps the low PIXEL_BITS bits of the zero-extended input.
  assign wide_in   = WIDE'($unsigned(in_pixel_in));
  assign ram_wdata = wide_in[PIXEL_BITS-1:0];

  ifrq_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ld_xfer),
    .waddr (ld_pos_r),
    .wdata (ram_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Result: stored pixel sign-extended from its width.
  assign rd_ext         = WIDE'($signed(ram_rdata));
  assign out_valid      = out_valid_r;
  assign out_pixel_out  = rd_ext[PIX_W-1:0];
  assign out_row_end    = out_tag_r.row_end;
  assign out_last_pixel = out_tag_r.last_pixel;

  // A store read only issues into an empty output slot.
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> !out_valid_r)
    else $error("store read issued while the output slot is occupied");

  // The read position lies inside the current view once the divider is done.
  a_rd_inside: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy |-> ((rd_col_r < cur_c) && (rd_row_r < cur_r)))
    else $error("read position outside the transformed image");

  // The load position lies inside the loaded image.
  a_ld_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_col_r < m_r) && (ld_row_r < n_r))
    else $error("load position outside the image");

  // After a rotation the divider is busy and input is held off.
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (div_busy && in_stall))
    else $error("input not held after a rotation");

endmodule

// ===== hdl/ifrq_ram.sv =====
// ----------------------------------------------------------------------------
// ifrq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module ifrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ifrq_addr.sv =====
// ----------------------------------------------------------------------------
// ifrq_addr
// Inverse address mapping: turns an output row and column into the address
// of the stored pixel; stage one is registered, stage two is combinational.
// ----------------------------------------------------------------------------
module ifrq_addr
  import ifrq_pkg::*;
#(
  parameter int MAX_DIM = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 issue,
  input  logic [$clog2(MAX_DIM+1)-1:0]         rd_row,
  input  logic [$clog2(MAX_DIM+1)-1:0]         rd_col,
  input  logic [$clog2(MAX_DIM+1)-1:0]         rows,
  input  logic [$clog2(MAX_DIM+1)-1:0]         cols,
  input  xform_t                               xform,
  output logic                                 re,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr,
  output rd_tag_t                              tag
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int PROD_W = 2 * DIM_W;

  logic [DIM_W-1:0] big_r, big_c, half_r, half_c, h_m1, w_m1, h, w;
  logic             qi, qj;
  logic [DIM_W-1:0] loc_r, loc_c, x, y;
  logic [1:0]       q;
  logic [DIM_W-1:0] row_sel, col_sel;
  rd_tag_t          tag_c;

  logic             s1_v_r, s1_v_nxt;
  logic [DIM_W-1:0] s1_row_r, s1_row_nxt, s1_col_r, s1_col_nxt;
  rd_tag_t          s1_tag_r, s1_tag_nxt;
  logic [PROD_W-1:0] prod;

  // Stage one: quadrant split, local mapping and quadrant map lookup.
  always_comb begin
    big_r  = xform.dir[0] ? rows : cols;
    big_c  = xform.dir[0] ? cols : rows;
    half_r = big_r >> 1;
    half_c = big_c >> 1;
    h      = rows >> 1;
    w      = cols >> 1;
    h_m1   = h - DIM_W'(1);
    w_m1   = w - DIM_W'(1);
    qi     = (rd_row >= half_r);
    qj     = (rd_col >= half_c);
    loc_r  = qi ? (rd_row - half_r) : rd_row;
    loc_c  = qj ? (rd_col - half_c) : rd_col;
    case ({xform.flip, xform.dir})
      3'd0: begin
        x = h_m1 - loc_c; y = loc_r;
      end
      3'd1: begin
        x = loc_r; y = loc_c;
      end
      3'd2: begin
        x = loc_c; y = w_m1 - loc_r;
      end
      3'd3: begin
        x = h_m1 - loc_r; y = w_m1 - loc_c;
      end
      3'd4: begin
        x = h_m1 - loc_c; y = w_m1 - loc_r;
      end
      3'd5: begin
        x = loc_r; y = w_m1 - loc_c;
      end
      3'd6: begin
        x = loc_c; y = loc_r;
      end
      default: begin
        x = h_m1 - loc_r; y = loc_c;
      end
    endcase
    q       = xform.qmap[{qi, qj}];
    row_sel = q[1] ? (h + x) : x;
    col_sel = q[0] ? (w + y) : y;
    tag_c.row_end    = (rd_col == big_c - DIM_W'(1));
    tag_c.last_pixel = tag_c.row_end && (rd_row == big_r - DIM_W'(1));

    s1_v_nxt   = issue;
    s1_row_nxt = issue ? row_sel : s1_row_r;
    s1_col_nxt = issue ? col_sel : s1_col_r;
    s1_tag_nxt = issue ? tag_c : s1_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    s1_row_r <= s1_row_nxt;
    s1_col_r <= s1_col_nxt;
    s1_tag_r <= s1_tag_nxt;
  end

  // Stage two: linear address into the row-major store.
  assign prod  = PROD_W'(s1_row_r) * PROD_W'(cols);
  assign raddr = POS_W'(prod + PROD_W'(s1_col_r));
  assign re    = s1_v_r;
  assign tag   = s1_tag_r;

endmodule

// ===== hdl/ifrq_div.sv =====
// ----------------------------------------------------------------------------
// ifrq_div
// Restoring divider, one quotient bit a cycle. Splits the linear read
// position into row and column after the output width has changed.
// ----------------------------------------------------------------------------
module ifrq_div
  import ifrq_pkg::*;
#(
  parameter int MAX_DIM = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   dividend,
  input  logic [$clog2(MAX_DIM+1)-1:0]         divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [$clog2(MAX_DIM+1)-1:0]         quotient,
  output logic [$clog2(MAX_DIM+1)-1:0]         remainder
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_W = ($clog2(POS_W) > 0) ? $clog2(POS_W) : 1;

  div_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] a_r, a_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt, d_r, d_nxt;
  logic             done_r, done_nxt;
  logic [DIM_W:0]   rem_sh, diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, try to subtract.
  always_comb begin
    rem_sh = {rem_r, a_r[POS_W-1]};
    diff   = rem_sh - {1'b0, d_r};
    ge     = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    done_nxt  = 1'b0;
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          state_nxt = DIV_RUN;
          cnt_nxt   = CNT_W'(POS_W - 1);
          a_nxt     = dividend;
          rem_nxt   = '0;
          d_nxt     = divisor;
        end
      end
      DIV_RUN: begin
        a_nxt   = {a_r[POS_W-2:0], ge};
        rem_nxt = ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        if (cnt_r == '0) begin
          state_nxt = DIV_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == DIV_RUN) || done_r;
  assign done      = done_r;
  assign quotient  = a_r[DIM_W-1:0];
  assign remainder = rem_r;

endmodule
